// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
// Needs nothing else; every macro reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define GBB_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define GBB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/gbb_pkg.sv
// Types and constants for the green blob bounding box block.
// No dependencies; imported by the top level and its checker.
package gbb_pkg;

  localparam int PIX_W      = 8;
  localparam int CNT_W      = 23;
  localparam int DIM_W      = 12;
  localparam int MARGIN_W   = 8;
  localparam int HUE_W      = 9;
  localparam int PCT_W      = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;
  localparam int HN_W       = 17;  // hue numerator, up to 360*255
  localparam int PROD_W     = 15;  // percent products, up to 127*255

  typedef logic [PIX_W-1:0]      pix_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  // Register indexes
  localparam cfg_idx_t CFG_FRAME_WIDTH  = 3'd0;
  localparam cfg_idx_t CFG_FRAME_HEIGHT = 3'd1;
  localparam cfg_idx_t CFG_MIN_COUNT    = 3'd2;
  localparam cfg_idx_t CFG_RGB_MARGIN   = 3'd3;
  localparam cfg_idx_t CFG_HUE_LOW      = 3'd4;
  localparam cfg_idx_t CFG_HUE_HIGH     = 3'd5;
  localparam cfg_idx_t CFG_SAT_MIN      = 3'd6;
  localparam cfg_idx_t CFG_VAL_MIN      = 3'd7;

  // Reset values
  localparam logic [DIM_W-1:0]    RST_FRAME_WIDTH  = 12'd640;
  localparam logic [DIM_W-1:0]    RST_FRAME_HEIGHT = 12'd480;
  localparam cnt_t                RST_MIN_COUNT    = 23'd100;
  localparam logic [MARGIN_W-1:0] RST_RGB_MARGIN   = 8'd40;
  localparam logic [HUE_W-1:0]    RST_HUE_LOW      = 9'd50;
  localparam logic [HUE_W-1:0]    RST_HUE_HIGH     = 9'd150;
  localparam logic [PCT_W-1:0]    RST_SAT_MIN      = 7'd30;
  localparam logic [PCT_W-1:0]    RST_VAL_MIN      = 7'd25;

  localparam cnt_t COUNT_MAX = {CNT_W{1'b1}};

  // Fixed-point HSV constants
  localparam logic [PROD_W-1:0] PCT_SCALE  = 15'd100;
  localparam logic [PROD_W-1:0] FULL_SCALE = 15'd255;
  localparam logic [HN_W-1:0]   DEG_60     = 17'd60;
  localparam logic [HN_W-1:0]   DEG_120    = 17'd120;
  localparam logic [HN_W-1:0]   DEG_240    = 17'd240;
  localparam logic [HN_W-1:0]   DEG_360    = 17'd360;

endpackage

// File: rtl/green_blob_bounding_box.sv
// A pixel enters the input register on accept and is classified from there; the frame
// result enters the output register when the frame's last pixel leaves the input register.
// Throughput: one pixel per cycle unless stalled; the box/count update is a feedback loop.
// The input register stalls only when a frame result cannot enter a full output register.
// Reset (synchronous, rst_n low): registers take their defaults, counters clear,
// both registers empty. Needs gbb_pkg.
module green_blob_bounding_box #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048,
  localparam int COL_W = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1,
  localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  gbb_pkg::cfg_idx_t   cfg_index,
  input  gbb_pkg::cfg_data_t  cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  gbb_pkg::pix_t       in_red,
  input  gbb_pkg::pix_t       in_green,
  input  gbb_pkg::pix_t       in_blue,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_found,
  output logic [COL_W:0]      out_box_left,
  output logic [ROW_W:0]      out_box_top,
  output logic [COL_W-1:0]    out_box_right,
  output logic [ROW_W-1:0]    out_box_bottom,
  output gbb_pkg::cnt_t       out_green_count
);
  import gbb_pkg::*;

  // Configuration registers
  logic [DIM_W-1:0]    frame_width_r, frame_height_r;
  cnt_t                min_count_r;
  logic [MARGIN_W-1:0] rgb_margin_r;
  logic [HUE_W-1:0]    hue_low_r, hue_high_r;
  logic [PCT_W-1:0]    sat_min_r, val_min_r;

  // Input register
  logic s1_valid_r;
  pix_t red_r, green_r, blue_r;

  // Frame state
  logic [COL_W-1:0] column_r, least_col_r, great_col_r;
  logic [ROW_W-1:0] row_r, least_row_r, great_row_r;
  cnt_t             hit_count_r;

  // Output register
  logic             out_valid_r, found_r;
  logic [COL_W:0]   left_r;
  logic [ROW_W:0]   top_r;
  logic [COL_W-1:0] right_r;
  logic [ROW_W-1:0] bottom_r;
  cnt_t             count_r;

  logic [COL_W:0] eff_w;
  logic [ROW_W:0] eff_h;
  logic           row_end, frame_end, out_free, s1_go, in_accept;

  // Classification
  pix_t             mx, mn, d;
  logic             red_max, green_max;
  logic [PROD_W-1:0] val_lhs, val_rhs, sat_lhs, sat_rhs;
  logic [HN_W-1:0]  hue_n, lo_d, hi_d;
  logic [PIX_W:0]   red_m, blue_m;
  logic             rgb_hit, hsv_hit, hit;

  // Updated frame state for the current pixel
  logic [COL_W-1:0] least_col_nxt, great_col_nxt;
  logic [ROW_W-1:0] least_row_nxt, great_row_nxt;
  cnt_t             hit_count_nxt;
  logic             any_hit;

  always_comb begin
    if (frame_width_r == '0) begin
      eff_w = (COL_W+1)'(1);
    end else if ({1'b0, frame_width_r} > 13'(MAX_WIDTH)) begin
      eff_w = (COL_W+1)'(MAX_WIDTH);
    end else begin
      eff_w = (COL_W+1)'(frame_width_r);
    end
    if (frame_height_r == '0) begin
      eff_h = (ROW_W+1)'(1);
    end else if ({1'b0, frame_height_r} > 13'(MAX_HEIGHT)) begin
      eff_h = (ROW_W+1)'(MAX_HEIGHT);
    end else begin
      eff_h = (ROW_W+1)'(frame_height_r);
    end
  end

  assign row_end   = {1'b0, column_r} >= (eff_w - 1'b1);
  assign frame_end = row_end && ({1'b0, row_r} >= (eff_h - 1'b1));

  assign out_free  = !out_valid_r || !out_stall;
  assign s1_go     = s1_valid_r && (!frame_end || out_free);
  assign in_stall  = s1_valid_r && !s1_go;
  assign in_accept = in_valid && !in_stall;

  // HSV window, ties on the maximum go to red, then green
  always_comb begin
    red_max   = (red_r >= green_r) && (red_r >= blue_r);
    green_max = !red_max && (green_r >= blue_r);
    mx = red_max ? red_r : (green_max ? green_r : blue_r);
    mn = red_r;
    if (green_r < mn) mn = green_r;
    if (blue_r < mn)  mn = blue_r;
    d = mx - mn;

    val_lhs = PROD_W'(mx) * PCT_SCALE;
    val_rhs = PROD_W'(val_min_r) * FULL_SCALE;
    sat_lhs = PROD_W'(d) * PCT_SCALE;
    sat_rhs = PROD_W'(sat_min_r) * PROD_W'(mx);

    // Hue numerator in degrees*d; true value is non-negative so wrapping is harmless
    if (red_max) begin
      if (green_r >= blue_r) begin
        hue_n = DEG_60 * HN_W'(green_r) - DEG_60 * HN_W'(blue_r);
      end else begin
        hue_n = DEG_360 * HN_W'(d) + DEG_60 * HN_W'(green_r) - DEG_60 * HN_W'(blue_r);
      end
    end else if (green_max) begin
      hue_n = DEG_120 * HN_W'(d) + DEG_60 * HN_W'(blue_r) - DEG_60 * HN_W'(red_r);
    end else begin
      hue_n = DEG_240 * HN_W'(d) + DEG_60 * HN_W'(red_r) - DEG_60 * HN_W'(green_r);
    end
    lo_d = HN_W'(hue_low_r) * HN_W'(d);
    hi_d = HN_W'(hue_high_r) * HN_W'(d);

    hsv_hit = (val_lhs > val_rhs) && (sat_lhs > sat_rhs) && (hue_n > lo_d) && (hue_n < hi_d);

    red_m   = {1'b0, red_r}  + {1'b0, rgb_margin_r};
    blue_m  = {1'b0, blue_r} + {1'b0, rgb_margin_r};
    rgb_hit = ({1'b0, green_r} > red_m) && ({1'b0, green_r} > blue_m);

    hit = rgb_hit || hsv_hit;
  end

  // Box and count update; the first hit of a frame loads the corners directly
  always_comb begin
    least_col_nxt = least_col_r;
    great_col_nxt = great_col_r;
    least_row_nxt = least_row_r;
    great_row_nxt = great_row_r;
    hit_count_nxt = hit_count_r;
    if (hit) begin
      if (hit_count_r == '0) begin
        least_col_nxt = column_r;
        great_col_nxt = column_r;
        least_row_nxt = row_r;
        great_row_nxt = row_r;
      end else begin
        if (column_r < least_col_r) least_col_nxt = column_r;
        if (column_r > great_col_r) great_col_nxt = column_r;
        if (row_r < least_row_r)    least_row_nxt = row_r;
        if (row_r > great_row_r)    great_row_nxt = row_r;
      end
      if (hit_count_r != COUNT_MAX) hit_count_nxt = hit_count_r + 1'b1;
    end
    any_hit = hit_count_nxt != '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= RST_FRAME_WIDTH;
      frame_height_r <= RST_FRAME_HEIGHT;
      min_count_r    <= RST_MIN_COUNT;
      rgb_margin_r   <= RST_RGB_MARGIN;
      hue_low_r      <= RST_HUE_LOW;
      hue_high_r     <= RST_HUE_HIGH;
      sat_min_r      <= RST_SAT_MIN;
      val_min_r      <= RST_VAL_MIN;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_data[DIM_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_data[DIM_W-1:0];
        CFG_MIN_COUNT:    min_count_r    <= cfg_data[CNT_W-1:0];
        CFG_RGB_MARGIN:   rgb_margin_r   <= cfg_data[MARGIN_W-1:0];
        CFG_HUE_LOW:      hue_low_r      <= cfg_data[HUE_W-1:0];
        CFG_HUE_HIGH:     hue_high_r     <= cfg_data[HUE_W-1:0];
        CFG_SAT_MIN:      sat_min_r      <= cfg_data[PCT_W-1:0];
        CFG_VAL_MIN:      val_min_r      <= cfg_data[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      column_r    <= '0;
      row_r       <= '0;
      hit_count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_accept || (s1_valid_r && !s1_go);
      if (s1_go) begin
        if (frame_end) begin
          column_r    <= '0;
          row_r       <= '0;
          hit_count_r <= '0;
        end else begin
          hit_count_r <= hit_count_nxt;
          if (row_end) begin
            column_r <= '0;
            row_r    <= row_r + 1'b1;
          end else begin
            column_r <= column_r + 1'b1;
          end
        end
      end
      if (s1_go && frame_end) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      red_r   <= in_red;
      green_r <= in_green;
      blue_r  <= in_blue;
    end
    if (s1_go) begin
      least_col_r <= least_col_nxt;
      great_col_r <= great_col_nxt;
      least_row_r <= least_row_nxt;
      great_row_r <= great_row_nxt;
    end
    if (s1_go && frame_end) begin
      found_r  <= hit_count_nxt > min_count_r;
      left_r   <= any_hit ? {1'b0, least_col_nxt} : eff_w;
      top_r    <= any_hit ? {1'b0, least_row_nxt} : eff_h;
      right_r  <= any_hit ? great_col_nxt : '0;
      bottom_r <= any_hit ? great_row_nxt : '0;
      count_r  <= hit_count_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = found_r;
  assign out_box_left    = left_r;
  assign out_box_top     = top_r;
  assign out_box_right   = right_r;
  assign out_box_bottom  = bottom_r;
  assign out_green_count = count_r;

endmodule

// File: rtl/gbb_checker.sv
// Port-level checks on the bounding box results, bound to the top level.
// Needs gbb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module gbb_checker #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048,
  localparam int COL_W = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1,
  localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic               out_found,
  input logic [COL_W:0]     out_box_left,
  input logic [ROW_W:0]     out_box_top,
  input logic [COL_W-1:0]   out_box_right,
  input logic [ROW_W-1:0]   out_box_bottom,
  input gbb_pkg::cnt_t      out_green_count
);
  import gbb_pkg::*;

  // A stalled request stays and keeps its count
  `GBB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_green_count), "result request dropped or changed while stalled")

  // With hits the box is not inverted
  `GBB_ASSERT_IMPLY(a_box_order, clk, rst_n, out_valid && out_green_count != '0, out_box_left <= {1'b0, out_box_right} && out_box_top <= {1'b0, out_box_bottom}, "inverted box")

  // Empty frame reports zero far corners and no find
  `GBB_ASSERT_IMPLY(a_empty_frame, clk, rst_n, out_valid && out_green_count == '0, out_box_right == '0 && out_box_bottom == '0 && !out_found, "empty frame result not cleared")

  // Found needs at least one hit
  `GBB_ASSERT_IMPLY(a_found_count, clk, rst_n, out_valid && out_found, out_green_count != '0, "found without green pixels")

endmodule

bind green_blob_bounding_box gbb_checker #(
  .MAX_WIDTH  (MAX_WIDTH),
  .MAX_HEIGHT (MAX_HEIGHT)
) u_gbb_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_found       (out_found),
  .out_box_left    (out_box_left),
  .out_box_top     (out_box_top),
  .out_box_right   (out_box_right),
  .out_box_bottom  (out_box_bottom),
  .out_green_count (out_green_count)
);

// File: tb/tb_green_blob_bounding_box.sv
// Testbench for green_blob_bounding_box: drives RGB pixel requests, predicts every frame box.
// Needs gbb_pkg and the green_blob_bounding_box RTL; nothing else.
`timescale 1ns / 100ps

module tb_green_blob_bounding_box;
  import gbb_pkg::*;

  localparam int MAX_DIM   = 2048;
  localparam int LATENCY   = 8;     // cycles for a pixel to clear both registers
  localparam int WATCHDOG  = 2000;  // cycles with no request moving on either side
  localparam int ITEMS     = 400;   // least pixel requests for the whole run
  localparam int CLAMP_RUN = 64;    // pixels pushed into each oversized frame

  typedef struct packed {
    logic [DIM_W-1:0]    width;
    logic [DIM_W-1:0]    height;
    cnt_t                min_count;
    logic [MARGIN_W-1:0] margin;
    logic [HUE_W-1:0]    hue_lo;
    logic [HUE_W-1:0]    hue_hi;
    logic [PCT_W-1:0]    sat_min;
    logic [PCT_W-1:0]    val_min;
  } frame_cfg_t;

  typedef struct packed {
    logic        found;
    logic [11:0] left;
    logic [11:0] top;
    logic [10:0] right;
    logic [10:0] bottom;
    cnt_t        count;
  } box_t;

  typedef enum logic [1:0] {ROW_SETUP, ROW_HIT, ROW_MISS, ROW_PREDICT} row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    pix_t       r;
    pix_t       g;
    pix_t       b;
    frame_cfg_t cfg;
  } row_t;

  localparam frame_cfg_t NO_CFG = '0;
  localparam frame_cfg_t ONE_BY_ONE =
    '{12'd1, 12'd1, 23'd0, 8'd40, 9'd50, 9'd150, 7'd30, 7'd25};
  // zero sizes fall back to 1x1; every threshold opened right up
  localparam frame_cfg_t ZERO_SIZE_OPEN =
    '{12'd0, 12'd0, 23'd0, 8'd0, 9'd0, 9'd360, 7'd0, 7'd0};
  localparam frame_cfg_t TWO_BY_TWO =
    '{12'd2, 12'd2, 23'd1, 8'd40, 9'd50, 9'd150, 7'd30, 7'd25};
  localparam frame_cfg_t WIDE_OPEN =
    '{12'd4095, 12'd1, 23'd0, 8'd0, 9'd0, 9'd360, 7'd0, 7'd0};
  localparam frame_cfg_t TALL_SHUT =
    '{12'd1, 12'd4095, 23'h7FFFFF, 8'd255, 9'd511, 9'd511, 7'd127, 7'd127};

  // single-pixel frames with a zero count threshold
  localparam box_t ONE_PX_HIT  = '{1'b1, 12'd0, 12'd0, 11'd0, 11'd0, 23'd1};
  localparam box_t ONE_PX_MISS = '{1'b0, 12'd1, 12'd1, 11'd0, 11'd0, 23'd0};

  localparam int PLAN_ROWS = 28;
  localparam row_t PLAN [PLAN_ROWS] = '{
    '{ROW_SETUP,   8'd0,   8'd0,   8'd0,   ONE_BY_ONE},
    '{ROW_HIT,     8'd0,   8'd255, 8'd0,   NO_CFG},
    '{ROW_MISS,    8'd0,   8'd0,   8'd0,   NO_CFG},
    '{ROW_MISS,    8'd255, 8'd255, 8'd255, NO_CFG},
    '{ROW_MISS,    8'd255, 8'd0,   8'd0,   NO_CFG},
    '{ROW_MISS,    8'd0,   8'd0,   8'd255, NO_CFG},
    '{ROW_PREDICT, 8'd255, 8'd255, 8'd0,   NO_CFG},  // red/green share the max
    '{ROW_PREDICT, 8'd0,   8'd255, 8'd255, NO_CFG},  // green/blue share the max
    '{ROW_PREDICT, 8'd255, 8'd0,   8'd255, NO_CFG},  // red/blue share the max
    '{ROW_PREDICT, 8'd100, 8'd141, 8'd100, NO_CFG},  // just over the margin
    '{ROW_PREDICT, 8'd100, 8'd140, 8'd100, NO_CFG},  // on the margin
    '{ROW_PREDICT, 8'd192, 8'd160, 8'd0,   NO_CFG},  // hue exactly on the lower bound
    '{ROW_PREDICT, 8'd192, 8'd161, 8'd0,   NO_CFG},
    '{ROW_PREDICT, 8'd0,   8'd200, 8'd100, NO_CFG},  // hue on the upper bound
    '{ROW_PREDICT, 8'd63,  8'd40,  8'd10,  NO_CFG},  // value just under its floor
    '{ROW_SETUP,   8'd0,   8'd0,   8'd0,   ZERO_SIZE_OPEN},
    '{ROW_HIT,     8'd0,   8'd1,   8'd0,   NO_CFG},
    '{ROW_MISS,    8'd0,   8'd0,   8'd0,   NO_CFG},
    '{ROW_PREDICT, 8'd255, 8'd0,   8'd0,   NO_CFG},
    '{ROW_SETUP,   8'd0,   8'd0,   8'd0,   TWO_BY_TWO},
    '{ROW_PREDICT, 8'd0,   8'd0,   8'd0,   NO_CFG},
    '{ROW_PREDICT, 8'd0,   8'd255, 8'd0,   NO_CFG},  // first hit loads the corners
    '{ROW_PREDICT, 8'd0,   8'd0,   8'd0,   NO_CFG},
    '{ROW_PREDICT, 8'd0,   8'd255, 8'd0,   NO_CFG},
    '{ROW_PREDICT, 8'd0,   8'd0,   8'd0,   NO_CFG},  // frame with nothing green
    '{ROW_PREDICT, 8'd0,   8'd0,   8'd0,   NO_CFG},
    '{ROW_PREDICT, 8'd0,   8'd0,   8'd0,   NO_CFG},
    '{ROW_PREDICT, 8'd0,   8'd0,   8'd0,   NO_CFG}
  };

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  cfg_idx_t    cfg_index;
  cfg_data_t   cfg_data;
  logic        in_valid;
  logic        in_stall;
  pix_t        in_red, in_green, in_blue;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_found;
  logic [11:0] out_box_left, out_box_top;
  logic [10:0] out_box_right, out_box_bottom;
  cnt_t        out_green_count;

  green_blob_bounding_box dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_found      (out_found),
    .out_box_left   (out_box_left),
    .out_box_top    (out_box_top),
    .out_box_right  (out_box_right),
    .out_box_bottom (out_box_bottom),
    .out_green_count(out_green_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // registers as the block holds them, and the frame tracker built on them
  frame_cfg_t  active_cfg;
  int unsigned trk_col, trk_row, trk_least_col, trk_least_row;
  int unsigned trk_great_col, trk_great_row, trk_hits;

  box_t expected_boxes [$];
  bit   quiet = 1'b0;
  int   pixels_sent = 0;
  int   errors = 0;
  int   rx_hold = 0;
  int   stuck = 0;

  function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  function automatic void clear_tracker();
    trk_col       = 0;
    trk_row       = 0;
    trk_least_col = clamp_dim(active_cfg.width);
    trk_least_row = clamp_dim(active_cfg.height);
    trk_great_col = 0;
    trk_great_row = 0;
    trk_hits      = 0;
  endfunction

  function automatic bit is_green(pix_t r, pix_t g, pix_t b);
    int unsigned ri, gi, bi, mx, mn, d, n;
    ri = r;
    gi = g;
    bi = b;
    if (gi > ri + active_cfg.margin && gi > bi + active_cfg.margin) return 1'b1;
    mx = ri;
    mn = ri;
    if (gi > mx) mx = gi;
    if (bi > mx) mx = bi;
    if (gi < mn) mn = gi;
    if (bi < mn) mn = bi;
    d = mx - mn;
    if (!(100 * mx > 255 * active_cfg.val_min)) return 1'b0;
    if (!(100 * d > active_cfg.sat_min * mx)) return 1'b0;
    // hue kept as numerator over d; ties on the max go to red, then green
    if (d == 0) n = 0;
    else if (mx == ri) n = (gi >= bi) ? 60 * (gi - bi) : 360 * d - 60 * (bi - gi);
    else if (mx == gi) n = 120 * d + 60 * bi - 60 * ri;
    else n = 240 * d + 60 * ri - 60 * gi;
    return n > active_cfg.hue_lo * d && n < active_cfg.hue_hi * d;
  endfunction

  // advances the tracker by one pixel; true when the pixel closes a frame
  function automatic bit track_pixel(pix_t r, pix_t g, pix_t b, output box_t box);
    int unsigned w, h;
    bit row_end;
    w = clamp_dim(active_cfg.width);
    h = clamp_dim(active_cfg.height);
    box = '0;
    if (is_green(r, g, b)) begin
      if (trk_hits == 0) begin
        trk_least_col = trk_col;
        trk_great_col = trk_col;
        trk_least_row = trk_row;
        trk_great_row = trk_row;
      end else begin
        if (trk_col < trk_least_col) trk_least_col = trk_col;
        if (trk_col > trk_great_col) trk_great_col = trk_col;
        if (trk_row < trk_least_row) trk_least_row = trk_row;
        if (trk_row > trk_great_row) trk_great_row = trk_row;
      end
      if (trk_hits < COUNT_MAX) trk_hits++;
    end
    row_end = trk_col >= w - 1;
    if (row_end && trk_row >= h - 1) begin
      box.found  = trk_hits > active_cfg.min_count;
      box.left   = 12'((trk_hits != 0) ? trk_least_col : w);
      box.top    = 12'((trk_hits != 0) ? trk_least_row : h);
      box.right  = 11'((trk_hits != 0) ? trk_great_col : 0);
      box.bottom = 11'((trk_hits != 0) ? trk_great_row : 0);
      box.count  = cnt_t'(trk_hits);
      clear_tracker();
      return 1'b1;
    end
    if (row_end) begin
      trk_col = 0;
      trk_row = (trk_row + 1) & 'h7FF;
    end else begin
      trk_col = (trk_col + 1) & 'h7FF;
    end
    return 1'b0;
  endfunction

  function automatic pix_t edge_chan();
    case ($urandom_range(0, 2))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void pick_pixel(output pix_t r, output pix_t g, output pix_t b);
    case ($urandom_range(0, 3))
      0: begin
        r = 8'($urandom_range(0, 255));
        g = 8'($urandom_range(0, 255));
        b = 8'($urandom_range(0, 255));
      end
      1: begin
        g = 8'($urandom_range(100, 255));
        r = 8'($urandom_range(0, g));
        b = 8'($urandom_range(0, g));
      end
      2: begin
        r = edge_chan();
        g = edge_chan();
        b = edge_chan();
        case ($urandom_range(0, 3))
          0: g = r;
          1: b = g;
          2: b = r;
          default: ;
        endcase
      end
      default: begin
        r = 8'($urandom_range(0, 80));
        g = 8'($urandom_range(0, 80));
        b = 8'($urandom_range(0, 80));
      end
    endcase
  endfunction

  function automatic frame_cfg_t draw_cfg();
    frame_cfg_t c;
    c.width  = ($urandom_range(0, 19) == 0) ? 12'd0 : 12'($urandom_range(1, 4));
    c.height = ($urandom_range(0, 19) == 0) ? 12'd0 : 12'($urandom_range(1, 4));
    case ($urandom_range(0, 3))
      0: c.min_count = '0;
      1: c.min_count = COUNT_MAX;
      default: c.min_count = cnt_t'($urandom_range(0, 6));
    endcase
    case ($urandom_range(0, 3))
      0: c.margin = 8'd0;
      1: c.margin = 8'd255;
      default: c.margin = 8'($urandom_range(0, 80));
    endcase
    case ($urandom_range(0, 3))
      0: c.hue_lo = 9'd0;
      1: c.hue_lo = 9'($urandom_range(300, 511));
      default: c.hue_lo = 9'($urandom_range(0, 180));
    endcase
    case ($urandom_range(0, 3))
      0: c.hue_hi = 9'd511;
      1: c.hue_hi = 9'd360;
      default: c.hue_hi = 9'(c.hue_lo + $urandom_range(0, 150));
    endcase
    case ($urandom_range(0, 3))
      0: c.sat_min = 7'd0;
      1: c.sat_min = 7'd127;
      default: c.sat_min = 7'($urandom_range(0, 60));
    endcase
    case ($urandom_range(0, 3))
      0: c.val_min = 7'd0;
      1: c.val_min = 7'd127;
      default: c.val_min = 7'($urandom_range(0, 60));
    endcase
    return c;
  endfunction

  // entered and left at a falling edge; write enable stays high for the caller to drop
  task automatic write_one(cfg_idx_t idx, cfg_data_t data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    case (idx)
      CFG_FRAME_WIDTH:  active_cfg.width     = data[DIM_W-1:0];
      CFG_FRAME_HEIGHT: active_cfg.height    = data[DIM_W-1:0];
      CFG_MIN_COUNT:    active_cfg.min_count = data[CNT_W-1:0];
      CFG_RGB_MARGIN:   active_cfg.margin    = data[MARGIN_W-1:0];
      CFG_HUE_LOW:      active_cfg.hue_lo    = data[HUE_W-1:0];
      CFG_HUE_HIGH:     active_cfg.hue_hi    = data[HUE_W-1:0];
      CFG_SAT_MIN:      active_cfg.sat_min   = data[PCT_W-1:0];
      CFG_VAL_MIN:      active_cfg.val_min   = data[PCT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_cfg(frame_cfg_t c);
    write_one(CFG_FRAME_WIDTH, cfg_data_t'(c.width));
    write_one(CFG_FRAME_HEIGHT, cfg_data_t'(c.height));
    write_one(CFG_MIN_COUNT, c.min_count);
    write_one(CFG_RGB_MARGIN, cfg_data_t'(c.margin));
    write_one(CFG_HUE_LOW, cfg_data_t'(c.hue_lo));
    write_one(CFG_HUE_HIGH, cfg_data_t'(c.hue_hi));
    write_one(CFG_SAT_MIN, cfg_data_t'(c.sat_min));
    write_one(CFG_VAL_MIN, cfg_data_t'(c.val_min));
    cfg_we <= 1'b0;
  endtask

  // valid is left high on return; the next request or settle() decides its level
  task automatic push_pixel(pix_t r, pix_t g, pix_t b, bit typed, box_t typed_box);
    int   gap;
    box_t box;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (track_pixel(r, g, b, box)) begin
      expected_boxes.push_back(typed ? typed_box : box);
    end
    pixels_sent++;
    @(negedge clk);
  endtask

  // hold off until every box is out, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_boxes.size() != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  // result side: stall draws per result, watchdog on request traffic
  always @(negedge clk) out_stall <= (rx_hold != 0);

  always @(posedge clk) begin
    box_t got, want;
    bit in_fire, out_fire;
    in_fire  = rst_n && in_valid && !in_stall;
    out_fire = rst_n && out_valid === 1'b1 && !out_stall;
    if (out_fire) begin
      got = '{out_found, out_box_left, out_box_top, out_box_right, out_box_bottom,
              out_green_count};
      if (expected_boxes.size() == 0) begin
        if (errors < 10)
          $display("unexpected box: found=%0d l=%0d t=%0d r=%0d b=%0d n=%0d",
                   got.found, got.left, got.top, got.right, got.bottom, got.count);
        errors++;
      end else begin
        want = expected_boxes.pop_front();
        if (got.found !== want.found || got.left !== want.left || got.top !== want.top ||
            got.right !== want.right || got.bottom !== want.bottom ||
            got.count !== want.count) begin
          if (errors < 10) begin
            $display("box mismatch: exp found=%0d l=%0d t=%0d r=%0d b=%0d n=%0d",
                     want.found, want.left, want.top, want.right, want.bottom,
                     want.count);
            $display("              got found=%0d l=%0d t=%0d r=%0d b=%0d n=%0d",
                     got.found, got.left, got.top, got.right, got.bottom, got.count);
          end
          errors++;
        end
      end
    end
    if (rst_n && out_valid === 1'b1) begin
      if (!out_stall) rx_hold = quiet ? 0 : $urandom_range(0, 3);
      else if (rx_hold != 0) rx_hold--;
    end
    if (in_fire || out_fire) begin
      stuck = 0;
    end else begin
      stuck = stuck + 1;
      if (stuck >= WATCHDOG) begin
        $display("tb_green_blob_bounding_box: errors");
        $finish;
      end
    end
  end

  initial begin
    pix_t r, g, b;
    int   len;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = CFG_FRAME_WIDTH;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_red    = '0;
    in_green  = '0;
    in_blue   = '0;
    active_cfg = '{RST_FRAME_WIDTH, RST_FRAME_HEIGHT, RST_MIN_COUNT, RST_RGB_MARGIN,
                   RST_HUE_LOW, RST_HUE_HIGH, RST_SAT_MIN, RST_VAL_MIN};
    clear_tracker();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // one column of eight rows, thresholds left at their reset values
    write_one(CFG_FRAME_WIDTH, cfg_data_t'(1));
    write_one(CFG_FRAME_HEIGHT, cfg_data_t'(8));
    cfg_we <= 1'b0;
    repeat (48) begin
      pick_pixel(r, g, b);
      push_pixel(r, g, b, 1'b0, '0);
    end

    for (int i = 0; i < PLAN_ROWS; i++) begin
      case (PLAN[i].kind)
        ROW_SETUP: begin
          settle();
          program_cfg(PLAN[i].cfg);
        end
        ROW_HIT:  push_pixel(PLAN[i].r, PLAN[i].g, PLAN[i].b, 1'b1, ONE_PX_HIT);
        ROW_MISS: push_pixel(PLAN[i].r, PLAN[i].g, PLAN[i].b, 1'b1, ONE_PX_MISS);
        default:  push_pixel(PLAN[i].r, PLAN[i].g, PLAN[i].b, 1'b0, '0);
      endcase
    end

    // oversized width clamps to 2048; a partial row, green at both ends, stays open
    settle();
    program_cfg(WIDE_OPEN);
    for (int c = 0; c < CLAMP_RUN; c++) begin
      if (c == 0 || c == CLAMP_RUN - 1) push_pixel(8'd0, 8'd255, 8'd0, 1'b0, '0);
      else push_pixel(8'd0, 8'd0, 8'd0, 1'b0, '0);
    end
    // oversized height, nothing can pass the thresholds; the open frame runs on a row a pixel
    settle();
    program_cfg(TALL_SHUT);
    repeat (CLAMP_RUN) begin
      pick_pixel(r, g, b);
      push_pixel(r, g, b, 1'b0, '0);
    end

    // random phases; a phase often ends mid-frame so the next size lands on a live frame
    while (pixels_sent < ITEMS) begin
      settle();
      quiet = ($urandom_range(0, 3) == 0);
      program_cfg(draw_cfg());
      len = $urandom_range(8, 40);
      repeat (len) begin
        if ($urandom_range(0, 39) == 0) settle();
        pick_pixel(r, g, b);
        push_pixel(r, g, b, 1'b0, '0);
      end
    end

    settle();
    if (errors == 0 && expected_boxes.size() == 0) begin
      $display("tb_green_blob_bounding_box: clean");
    end else begin
      $display("tb_green_blob_bounding_box: errors");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/gbb_pkg.sv
rtl/green_blob_bounding_box.sv
rtl/gbb_checker.sv
tb/tb_green_blob_bounding_box.sv
